// ----- hdl/ssdp_srp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP request parser package
// Shared types, phase and header codes, literal tokens and default sizes.
// ----------------------------------------------------------------------------
package ssdp_srp_pkg;

   localparam int TOKEN_DEPTH_DEF  = 32;
   localparam int METHOD_LIMIT_DEF = 16;
   localparam int URI_LIMIT_DEF    = 16;

   localparam logic [2:0] PH_METHOD = 3'd0;
   localparam logic [2:0] PH_URI    = 3'd1;
   localparam logic [2:0] PH_PROTO  = 3'd2;
   localparam logic [2:0] PH_KEY    = 3'd3;
   localparam logic [2:0] PH_VALUE  = 3'd4;
   localparam logic [2:0] PH_ABORT  = 3'd5;

   localparam logic [1:0] HD_NONE = 2'd0;
   localparam logic [1:0] HD_MAN  = 2'd1;
   localparam logic [1:0] HD_ST   = 2'd2;
   localparam logic [1:0] HD_MX   = 2'd3;

   localparam logic [1:0] MTH_NONE    = 2'd0;
   localparam logic [1:0] MTH_MSEARCH = 2'd1;
   localparam logic [1:0] MTH_NOTIFY  = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [2:0] RUN_MAX   = 3'd7;
   localparam logic [2:0] RUN_EOL   = 3'd2;
   localparam logic [2:0] RUN_BLANK = 3'd4;

   localparam logic [63:0] LIT_MSEARCH = "M-SEARCH";
   localparam logic [63:0] LIT_NOTIFY  = "NOTIFY";
   localparam logic [63:0] LIT_STAR    = "*";
   localparam logic [63:0] LIT_SSDPALL = "ssdp:all";
   localparam logic [63:0] LIT_ST      = "ST";
   localparam logic [63:0] LIT_MX      = "MX";
   localparam logic [63:0] LIT_MA      = "MA";

   localparam logic [3:0] LEN_MSEARCH = 4'd8;
   localparam logic [3:0] LEN_NOTIFY  = 4'd6;
   localparam logic [3:0] LEN_STAR    = 4'd1;
   localparam logic [3:0] LEN_SSDPALL = 4'd8;
   localparam logic [3:0] LEN_TWO     = 4'd2;

   typedef struct packed {
      logic [7:0] data;
      logic       pkt_start;
      logic       pkt_end;
      logic       brk;
      logic       space;
      logic       colon;
      logic [2:0] run;
   } beat_type;

endpackage

// ----- hdl/ssdp_srp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP request parser front end
// Accepts request beats, classifies each byte and counts line break runs.
// ----------------------------------------------------------------------------
module ssdp_srp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_packet_start,
   input  logic                   req_packet_end,
   input  logic                   q_full,
   output logic                   push,
   output ssdp_srp_pkg::beat_type beat
);
   import ssdp_srp_pkg::*;

   logic [2:0] run_ff;
   logic [2:0] run_in;
   logic       brk;
   logic [2:0] run_base;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;
   assign brk       = (req_data_byte == CH_CR) || (req_data_byte == CH_LF);
   assign run_base  = req_packet_start ? 3'd0 : run_ff;

   always_comb begin
      if (!brk) begin
         run_in = 3'd0;
      end else if (run_base == RUN_MAX) begin
         run_in = RUN_MAX;
      end else begin
         run_in = run_base + 3'd1;
      end
   end

   always_comb begin
      beat.data      = req_data_byte;
      beat.pkt_start = req_packet_start;
      beat.pkt_end   = req_packet_end;
      beat.brk       = brk;
      beat.space     = (req_data_byte == CH_SPACE);
      beat.colon     = (req_data_byte == CH_COLON);
      beat.run       = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 3'd0;
      end else if (push) begin
         run_ff <= run_in;
      end
   end

endmodule

// ----- hdl/ssdp_srp_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP request parser beat queue
// Two-entry queue of classified beats between front end and back end.
// ----------------------------------------------------------------------------
module ssdp_srp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ssdp_srp_pkg::beat_type push_beat,
   input  logic                   pop,
   output logic                   q_valid,
   output logic                   q_full,
   output ssdp_srp_pkg::beat_type q_beat
);
   import ssdp_srp_pkg::*;

   beat_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign q_beat  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push) else $error("beat written into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("beat read from empty queue");

endmodule

// ----- hdl/ssdp_srp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP request parser back end
// Runs the request phase machine, token match flags and MX conversion.
// ----------------------------------------------------------------------------
module ssdp_srp_back #(
   parameter int TOKEN_DEPTH  = ssdp_srp_pkg::TOKEN_DEPTH_DEF,
   parameter int METHOD_LIMIT = ssdp_srp_pkg::METHOD_LIMIT_DEF,
   parameter int URI_LIMIT    = ssdp_srp_pkg::URI_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ssdp_srp_pkg::beat_type q_beat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic                   rsp_rejected,
   output logic [1:0]             rsp_method_kind,
   output logic [15:0]            rsp_mx_seconds
);
   import ssdp_srp_pkg::*;

   localparam int FW      = $clog2(TOKEN_DEPTH);
   localparam int DLIM_I  = TOKEN_DEPTH - 1;
   localparam int MLIM_I  = (METHOD_LIMIT - 1 < DLIM_I) ? METHOD_LIMIT - 1 : DLIM_I;
   localparam int ULIM_I  = (URI_LIMIT - 1 < DLIM_I) ? URI_LIMIT - 1 : DLIM_I;
   localparam logic [FW-1:0] DLIM = FW'(DLIM_I);
   localparam logic [FW-1:0] MLIM = FW'(MLIM_I);
   localparam logic [FW-1:0] ULIM = FW'(ULIM_I);

   localparam logic [1:0] NUM_SKIP = 2'd0;
   localparam logic [1:0] NUM_DIG  = 2'd1;
   localparam logic [1:0] NUM_DONE = 2'd2;

   typedef struct packed {
      logic [FW-1:0] tlen;
      logic          zcut;
      logic          pm_msearch;
      logic          pm_notify;
      logic          pm_star;
      logic          pm_ssdpall;
      logic          pm_st;
      logic          pm_mx;
      logic          pm_ma;
      logic [1:0]    num_st;
      logic          neg;
      logic [15:0]   acc;
   } desc_type;

   function automatic desc_type desc_clear();
      desc_type d;
      d            = '0;
      d.pm_msearch = 1'b1;
      d.pm_notify  = 1'b1;
      d.pm_star    = 1'b1;
      d.pm_ssdpall = 1'b1;
      d.pm_st      = 1'b1;
      d.pm_mx      = 1'b1;
      d.pm_ma      = 1'b1;
      d.num_st     = NUM_SKIP;
      return d;
   endfunction

   function automatic logic pm_step(logic pm, logic [63:0] lit, logic [3:0] n,
                                    logic [FW-1:0] k, logic [7:0] c);
      logic       hit;
      logic [5:0] sh;
      hit = 1'b1;
      sh  = 6'd0;
      if (k < FW'(n)) begin
         sh  = {3'(n - 4'd1 - {1'b0, k[2:0]}), 3'b000};
         hit = (c == lit[sh +: 8]);
      end
      return pm && hit;
   endfunction

   function automatic desc_type desc_push(desc_type d_in, logic [FW-1:0] k,
                                          logic [7:0] c);
      desc_type    d;
      logic        isdig;
      logic        isws;
      logic [3:0]  dig;
      logic [19:0] prod;
      d     = (k == '0) ? desc_clear() : d_in;
      isdig = (c >= "0") && (c <= "9");
      isws  = (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
      dig   = 4'(c - "0");
      prod  = 20'(d.acc) * 20'd10 + 20'(dig);
      if (!d.zcut) begin
         if (c == 8'h00) begin
            d.zcut = 1'b1;
         end else begin
            d.tlen       = k + FW'(1);
            d.pm_msearch = pm_step(d.pm_msearch, LIT_MSEARCH, LEN_MSEARCH, k, c);
            d.pm_notify  = pm_step(d.pm_notify, LIT_NOTIFY, LEN_NOTIFY, k, c);
            d.pm_star    = pm_step(d.pm_star, LIT_STAR, LEN_STAR, k, c);
            d.pm_ssdpall = pm_step(d.pm_ssdpall, LIT_SSDPALL, LEN_SSDPALL, k, c);
            d.pm_st      = pm_step(d.pm_st, LIT_ST, LEN_TWO, k, c);
            d.pm_mx      = pm_step(d.pm_mx, LIT_MX, LEN_TWO, k, c);
            d.pm_ma      = pm_step(d.pm_ma, LIT_MA, LEN_TWO, k, c);
            case (d.num_st)
               NUM_SKIP: begin
                  if (isws) begin
                     d.num_st = NUM_SKIP;
                  end else if ((c == "+") || (c == "-")) begin
                     d.neg    = (c == "-");
                     d.num_st = NUM_DIG;
                  end else if (isdig) begin
                     d.acc    = 16'(dig);
                     d.num_st = NUM_DIG;
                  end else begin
                     d.num_st = NUM_DONE;
                  end
               end
               NUM_DIG: begin
                  if (isdig) begin
                     d.acc = (prod > 20'd65535) ? 16'hFFFF : 16'(prod);
                  end else begin
                     d.num_st = NUM_DONE;
                  end
               end
               default: begin
                  d.num_st = d.num_st;
               end
            endcase
         end
      end
      return d;
   endfunction

   function automatic logic text_is(logic pm, logic [FW-1:0] tlen, logic [3:0] n);
      return pm && (tlen == FW'(n));
   endfunction

   logic [2:0]    phase_ff, phase_in, ph_cur;
   logic [1:0]    hdr_ff, hdr_in, hd_cur;
   logic [FW-1:0] fill_ff, fill_in, fill_cur;
   logic [1:0]    meth_ff, meth_in, meth_cur;
   logic          pend_ff, pend_in, pend_cur;
   logic [15:0]   mx_ff, mx_in, mx_cur;
   desc_type      desc_ff, desc_in, desc_cur, desc_app;
   logic          app_en;
   logic [FW-1:0] app_lim;
   logic [1:0]    meth_new;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          acc_ff, rej_ff;
   logic [1:0]    mk_ff;
   logic [15:0]   mxs_ff;

   assign pop = q_valid && (!q_beat.pkt_end || !rsp_valid_ff || rsp_ready);

   always_comb begin
      ph_cur   = q_beat.pkt_start ? PH_METHOD : phase_ff;
      hd_cur   = q_beat.pkt_start ? HD_NONE : hdr_ff;
      fill_cur = q_beat.pkt_start ? '0 : fill_ff;
      meth_cur = q_beat.pkt_start ? MTH_NONE : meth_ff;
      pend_cur = q_beat.pkt_start ? 1'b0 : pend_ff;
      mx_cur   = q_beat.pkt_start ? 16'd0 : mx_ff;
      desc_cur = q_beat.pkt_start ? desc_clear() : desc_ff;
      desc_app = desc_push(desc_cur, fill_cur, q_beat.data);

      phase_in = ph_cur;
      hdr_in   = hd_cur;
      fill_in  = fill_cur;
      meth_in  = meth_cur;
      pend_in  = pend_cur;
      mx_in    = mx_cur;
      app_en   = 1'b0;
      app_lim  = DLIM;
      meth_new = meth_cur;

      case (ph_cur)
         PH_METHOD: begin
            if (q_beat.space) begin
               if (text_is(desc_cur.pm_msearch, desc_cur.tlen, LEN_MSEARCH)) begin
                  meth_new = MTH_MSEARCH;
               end else if (text_is(desc_cur.pm_notify, desc_cur.tlen, LEN_NOTIFY)) begin
                  meth_new = MTH_NOTIFY;
               end
               meth_in  = meth_new;
               phase_in = (meth_new == MTH_NONE) ? PH_ABORT : PH_URI;
               fill_in  = '0;
            end else begin
               app_en  = 1'b1;
               app_lim = MLIM;
            end
         end
         PH_URI: begin
            if (q_beat.space) begin
               phase_in = text_is(desc_cur.pm_star, desc_cur.tlen, LEN_STAR) ?
                          PH_PROTO : PH_ABORT;
               fill_in  = '0;
            end else begin
               app_en  = 1'b1;
               app_lim = ULIM;
            end
         end
         PH_PROTO: begin
            if (q_beat.run == RUN_EOL) begin
               phase_in = PH_KEY;
               fill_in  = '0;
            end
         end
         PH_KEY: begin
            if (q_beat.run == RUN_BLANK) begin
               pend_in = 1'b1;
            end else if (q_beat.space) begin
               fill_in  = '0;
               phase_in = PH_VALUE;
            end else if (!q_beat.brk && !q_beat.colon) begin
               app_en = 1'b1;
            end
         end
         PH_VALUE: begin
            if (q_beat.run == RUN_EOL) begin
               if ((hd_cur == HD_ST) &&
                   !text_is(desc_cur.pm_ssdpall, desc_cur.tlen, LEN_SSDPALL)) begin
                  phase_in = PH_ABORT;
               end else begin
                  if (hd_cur == HD_MX) begin
                     mx_in = desc_cur.neg ? 16'd0 : desc_cur.acc;
                  end
                  phase_in = PH_KEY;
                  hdr_in   = HD_NONE;
                  fill_in  = '0;
               end
            end else if (!q_beat.brk) begin
               if (hd_cur == HD_NONE) begin
                  if (desc_cur.pm_ma && (desc_cur.tlen >= FW'(2))) begin
                     hdr_in = HD_MAN;
                  end else if (text_is(desc_cur.pm_st, desc_cur.tlen, LEN_TWO)) begin
                     hdr_in = HD_ST;
                  end else if (text_is(desc_cur.pm_mx, desc_cur.tlen, LEN_TWO)) begin
                     hdr_in = HD_MX;
                  end
               end
               app_en = 1'b1;
            end
         end
         PH_ABORT: begin
            pend_in = 1'b0;
            mx_in   = 16'd0;
         end
         default: begin
            phase_in = ph_cur;
         end
      endcase

      desc_in = desc_cur;
      if (app_en && (fill_cur < app_lim)) begin
         desc_in = desc_app;
         fill_in = fill_cur + FW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && q_beat.pkt_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_METHOD;
         hdr_ff       <= HD_NONE;
         fill_ff      <= '0;
         meth_ff      <= MTH_NONE;
         pend_ff      <= 1'b0;
         mx_ff        <= 16'd0;
         desc_ff      <= desc_clear();
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            hdr_ff   <= hdr_in;
            fill_ff  <= fill_in;
            meth_ff  <= meth_in;
            pend_ff  <= pend_in;
            mx_ff    <= mx_in;
            desc_ff  <= desc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && q_beat.pkt_end) begin
         acc_ff <= pend_in;
         rej_ff <= (phase_in == PH_ABORT);
         mk_ff  <= meth_in;
         mxs_ff <= mx_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_rejected    = rej_ff;
   assign rsp_method_kind = mk_ff;
   assign rsp_mx_seconds  = mxs_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DLIM) else $error("token cursor past store depth");
   a_method_known: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_URI || phase_ff == PH_PROTO || phase_ff == PH_KEY ||
       phase_ff == PH_VALUE) |-> (meth_ff != MTH_NONE))
      else $error("request line passed without a known method");
   a_header_phase: assert property (@(posedge clock) disable iff (reset)
      (hdr_ff != HD_NONE) |-> (phase_ff == PH_VALUE || phase_ff == PH_ABORT))
      else $error("header kind held outside value phase");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(mxs_ff)))
      else $error("pending result lost");

endmodule

// ----- hdl/ssdp_search_request_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP search request parser
// Parses one datagram a byte per beat and reports the request outcome.
// ----------------------------------------------------------------------------
// The parser takes one payload byte per clock cycle while the queue has room.
// A front end accepts and classifies each byte (line break, space, colon,
// running CR/LF count) and writes it into a two-entry queue; the back end
// drains it at one byte per cycle, holding a last byte while a result is
// unread, and advances the request phase, per-literal match flags and the MX
// decimal accumulator. On a last beat the result is registered as it is
// popped, then waits in the output register while further bytes flow into
// the queue. Token text is tracked through match flags and never stored, so
// there is no memory and no clearing pass after reset.
module ssdp_search_request_parser #(
   parameter int TOKEN_DEPTH  = ssdp_srp_pkg::TOKEN_DEPTH_DEF,
   parameter int METHOD_LIMIT = ssdp_srp_pkg::METHOD_LIMIT_DEF,
   parameter int URI_LIMIT    = ssdp_srp_pkg::URI_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_start,
   input  logic        req_packet_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_rejected,
   output logic [1:0]  rsp_method_kind,
   output logic [15:0] rsp_mx_seconds
);
   import ssdp_srp_pkg::*;

   logic     push;
   logic     pop;
   logic     q_valid;
   logic     q_full;
   beat_type push_beat;
   beat_type q_beat;

   ssdp_srp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_packet_start (req_packet_start),
      .req_packet_end   (req_packet_end),
      .q_full           (q_full),
      .push             (push),
      .beat             (push_beat)
   );

   ssdp_srp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .q_beat    (q_beat)
   );

   ssdp_srp_back #(
      .TOKEN_DEPTH  (TOKEN_DEPTH),
      .METHOD_LIMIT (METHOD_LIMIT),
      .URI_LIMIT    (URI_LIMIT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_beat          (q_beat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accepted    (rsp_accepted),
      .rsp_rejected    (rsp_rejected),
      .rsp_method_kind (rsp_method_kind),
      .rsp_mx_seconds  (rsp_mx_seconds)
   );

endmodule

// ----- verif/ssdp_srp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP request parser checker
// Watches the byte and outcome channels of the parser. Each accepted byte is
// run through a local model of the request parse; every byte marked as the
// end of a datagram queues the predicted outcome. Each accepted outcome beat
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ssdp_srp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_start,
   input  logic        req_packet_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic        rsp_rejected,
   input  logic [1:0]  rsp_method_kind,
   input  logic [15:0] rsp_mx_seconds,
   output int          mismatch_count,
   output int          outcomes_pending,
   output int          outcome_count,
   output int          accept_count,
   output int          reject_count
);
   import ssdp_srp_pkg::*;

   typedef struct packed {
      logic        accepted;
      logic        rejected;
      logic [1:0]  method_kind;
      logic [15:0] mx_seconds;
   } outcome_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_WS_LO = 8'h09;
   localparam logic [7:0] CH_WS_HI = 8'h0D;
   localparam int unsigned MX_SAT  = 65535;

   logic [2:0]  phase;
   logic [1:0]  header;
   logic [2:0]  break_run;
   int unsigned cursor;
   logic [7:0]  token [TOKEN_DEPTH_DEF];
   int unsigned token_len;
   logic [1:0]  method;
   logic        request_done;
   logic [15:0] mx_secs;

   outcome_type expected_outcomes[$];
   outcome_type got;
   outcome_type want;
   int mismatches;
   int seen;
   int accepts;
   int rejects;

   function automatic void clear_request();
      int i;
      phase        = PH_METHOD;
      header       = HD_NONE;
      break_run    = '0;
      cursor       = 0;
      token_len    = 0;
      method       = MTH_NONE;
      request_done = 1'b0;
      mx_secs      = '0;
      for (i = 0; i < TOKEN_DEPTH_DEF; i++) token[i] = CH_NUL;
   endfunction

   function automatic int unsigned text_length();
      int unsigned n;
      int unsigned i;
      n = (token_len > TOKEN_DEPTH_DEF) ? TOKEN_DEPTH_DEF : token_len;
      for (i = 0; i < n; i++)
         if (token[i] == CH_NUL) return i;
      return n;
   endfunction

   function automatic bit token_equals(input logic [63:0] lit, input int unsigned n);
      int unsigned i;
      if (text_length() != n) return 1'b0;
      for (i = 0; i < n; i++)
         if (token[i] != lit[8*(n-1-i) +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void store_byte(input logic [7:0] c, input int unsigned limit);
      int unsigned lim;
      lim = (limit > 0) ? limit - 1 : 0;
      if (lim > TOKEN_DEPTH_DEF - 1) lim = TOKEN_DEPTH_DEF - 1;
      if (cursor < lim) begin
         token[cursor] = c;
         cursor++;
         token_len = cursor;
      end
   endfunction

   function automatic void predict_byte(input logic [7:0] c, input logic first,
                                        input logic last);
      bit          is_break;
      bit          neg;
      int unsigned i;
      int unsigned n;
      int unsigned acc;
      if (first) clear_request();
      is_break = (c == CH_CR) || (c == CH_LF);
      if (is_break) begin
         if (break_run < RUN_MAX) break_run++;
      end else begin
         break_run = '0;
      end
      case (phase)
         PH_METHOD: begin
            if (c == CH_SPACE) begin
               if (token_equals(LIT_MSEARCH, LEN_MSEARCH)) method = MTH_MSEARCH;
               else if (token_equals(LIT_NOTIFY, LEN_NOTIFY)) method = MTH_NOTIFY;
               phase  = (method == MTH_NONE) ? PH_ABORT : PH_URI;
               cursor = 0;
            end else begin
               store_byte(c, METHOD_LIMIT_DEF);
            end
         end
         PH_URI: begin
            if (c == CH_SPACE) begin
               phase  = token_equals(LIT_STAR, LEN_STAR) ? PH_PROTO : PH_ABORT;
               cursor = 0;
            end else begin
               store_byte(c, URI_LIMIT_DEF);
            end
         end
         PH_PROTO: begin
            if (break_run == RUN_EOL) begin
               phase  = PH_KEY;
               cursor = 0;
            end
         end
         PH_KEY: begin
            if (break_run == RUN_BLANK) begin
               request_done = 1'b1;
            end else if (c == CH_SPACE) begin
               cursor = 0;
               phase  = PH_VALUE;
            end else if (!is_break && c != CH_COLON) begin
               store_byte(c, TOKEN_DEPTH_DEF);
            end
         end
         PH_VALUE: begin
            if (break_run == RUN_EOL) begin
               if (header == HD_ST) begin
                  if (!token_equals(LIT_SSDPALL, LEN_SSDPALL)) phase = PH_ABORT;
               end else if (header == HD_MX) begin
                  n   = text_length();
                  i   = 0;
                  acc = 0;
                  neg = 1'b0;
                  while (i < n && (token[i] == CH_SPACE ||
                                   (token[i] >= CH_WS_LO && token[i] <= CH_WS_HI)))
                     i++;
                  if (i < n && (token[i] == "+" || token[i] == "-")) begin
                     neg = (token[i] == "-");
                     i++;
                  end
                  while (i < n && token[i] >= "0" && token[i] <= "9") begin
                     acc = acc * 10 + (token[i] - "0");
                     if (acc > MX_SAT) acc = MX_SAT;
                     i++;
                  end
                  mx_secs = neg ? 16'd0 : acc[15:0];
               end
               if (phase != PH_ABORT) begin
                  phase  = PH_KEY;
                  header = HD_NONE;
                  cursor = 0;
               end
            end else if (!is_break) begin
               if (header == HD_NONE) begin
                  if (text_length() >= 2 && token[0] == LIT_MA[15:8] &&
                      token[1] == LIT_MA[7:0])
                     header = HD_MAN;
                  else if (token_equals(LIT_ST, LEN_TWO))
                     header = HD_ST;
                  else if (token_equals(LIT_MX, LEN_TWO))
                     header = HD_MX;
               end
               store_byte(c, TOKEN_DEPTH_DEF);
            end
         end
         PH_ABORT: begin
            request_done = 1'b0;
            mx_secs      = '0;
         end
         default: ;
      endcase
      if (last)
         expected_outcomes.push_back('{request_done, phase == PH_ABORT, method, mx_secs});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_request();
         expected_outcomes.delete();
         mismatches = 0;
         seen       = 0;
         accepts    = 0;
         rejects    = 0;
      end else begin
         if (req_valid && req_ready)
            predict_byte(req_data_byte, req_packet_start, req_packet_end);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_accepted, rsp_rejected, rsp_method_kind, rsp_mx_seconds};
            seen++;
            if (got.accepted) accepts++;
            if (got.rejected) rejects++;
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected outcome: acc=%0b rej=%0b method=%0d mx=%0d",
                           $realtime, got.accepted, got.rejected, got.method_kind,
                           got.mx_seconds);
            end else begin
               want = expected_outcomes.pop_front();
               if (want != got) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("[%0t] outcome %0d: expected acc=%0b rej=%0b method=%0d mx=%0d",
                              $realtime, seen, want.accepted, want.rejected,
                              want.method_kind, want.mx_seconds);
                     $display("    got acc=%0b rej=%0b method=%0d mx=%0d",
                              got.accepted, got.rejected, got.method_kind,
                              got.mx_seconds);
                  end
               end
            end
         end
      end
      mismatch_count   <= mismatches;
      outcomes_pending <= expected_outcomes.size();
      outcome_count    <= seen;
      accept_count     <= accepts;
      reject_count     <= rejects;
   end

endmodule

// ----- verif/ssdp_search_request_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSDP search request parser testbench
// Feeds datagram bytes to the parser: a short directed opening, then mostly
// well-formed M-SEARCH and NOTIFY requests with random headers, MX values and
// framing, mixed with noise and corrupted datagrams. Both channels idle at
// random and the outcome side holds off once for a long stretch. A separate
// checker predicts and compares every outcome.
// ----------------------------------------------------------------------------
module ssdp_search_request_parser_tb;
   import ssdp_srp_pkg::*;

   localparam int ITEM_TARGET    = 1150;
   localparam int OUTCOME_TARGET = 48;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 20;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_A   = 8'h41;
   localparam logic [7:0] CH_Z   = 8'h5A;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_9   = 8'h39;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_packet_start;
   logic        req_packet_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic        rsp_rejected;
   logic [1:0]  rsp_method_kind;
   logic [15:0] rsp_mx_seconds;
   logic        hold_trigger;

   int mismatch_count;
   int outcomes_pending;
   int outcome_count;
   int accept_count;
   int reject_count;
   int bytes_sent;
   int ends_sent;
   int datagrams_sent;
   bit no_idle;
   logic [7:0] datagram[$];

   ssdp_search_request_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_packet_start (req_packet_start),
      .req_packet_end   (req_packet_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_rejected     (rsp_rejected),
      .rsp_method_kind  (rsp_method_kind),
      .rsp_mx_seconds   (rsp_mx_seconds)
   );

   ssdp_srp_checker outcome_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_packet_start (req_packet_start),
      .req_packet_end   (req_packet_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_rejected     (rsp_rejected),
      .rsp_method_kind  (rsp_method_kind),
      .rsp_mx_seconds   (rsp_mx_seconds),
      .mismatch_count   (mismatch_count),
      .outcomes_pending (outcomes_pending),
      .outcome_count    (outcome_count),
      .accept_count     (accept_count),
      .reject_count     (reject_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic drive_byte(input logic [7:0] d, input logic first, input logic last);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= d;
      req_packet_start <= first;
      req_packet_end   <= last;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (last) ends_sent++;
   endtask

   task automatic send_datagram(input bit with_start, input bit with_end, input bit stray);
      int  i;
      logic first;
      logic last;
      for (i = 0; i < datagram.size(); i++) begin
         first = with_start && (i == 0);
         last  = (with_end && i == datagram.size() - 1) ||
                 (stray && $urandom_range(0, 49) == 0);
         drive_byte(datagram[i], first, last);
      end
      datagram.delete();
      datagrams_sent++;
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) datagram.push_back(s[i]);
   endtask

   task automatic push_word(input int len);
      repeat (len) datagram.push_back(8'($urandom_range(CH_A, CH_Z)));
   endtask

   task automatic push_noise(input int len);
      repeat (len) datagram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic push_eol();
      datagram.push_back(CH_CR);
      datagram.push_back(CH_LF);
   endtask

   task automatic push_mx_value();
      int r;
      repeat ($urandom_range(0, 2))
         datagram.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE :
                            8'($urandom_range(CH_TAB, CH_FF)));
      r = $urandom_range(0, 99);
      if (r < 10) push_text("+");
      else if (r < 20) push_text("-");
      repeat (($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(4, 7))
         datagram.push_back(8'($urandom_range(CH_0, CH_9)));
      if ($urandom_range(0, 4) == 0) push_word($urandom_range(1, 3));
   endtask

   task automatic push_header();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 30) push_text("ST");
      else if (r < 55) push_text("MX");
      else if (r < 70) push_text("MAN");
      else if (r < 80) push_text("HOST");
      else push_word($urandom_range(1, 6));
      if ($urandom_range(0, 9) != 0) datagram.push_back(CH_COLON);
      datagram.push_back(CH_SPACE);
      v = $urandom_range(0, 99);
      if (r < 30) begin
         if (v < 60) push_text("ssdp:all");
         else if (v < 75) push_text("ssdp:al");
         else if (v < 90) push_text("upnp:rootdevice");
         else push_word($urandom_range(0, 10));
      end else if (r < 55) begin
         push_mx_value();
      end else if (r < 70) begin
         push_text("\"ssdp:discover\"");
      end else if (r < 80) begin
         if (v < 80) push_text("host:1900");
         else push_word($urandom_range(33, 40));
      end else begin
         push_noise($urandom_range(0, 6));
      end
      push_eol();
   endtask

   task automatic build_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) push_text("M-SEARCH");
      else if (r < 75) push_text("NOTIFY");
      else if (r < 85) push_word($urandom_range(0, 20));
      else begin
         push_text("M-SEARCH");
         push_word($urandom_range(1, 12));
      end
      datagram.push_back(CH_SPACE);
      r = $urandom_range(0, 99);
      if (r < 85) push_text("*");
      else if (r < 92) push_word($urandom_range(0, 20));
      else push_text("*/");
      push_text(" HTTP/1.1");
      push_eol();
      repeat ($urandom_range(0, 3)) push_header();
      r = $urandom_range(0, 99);
      if (r < 85) begin
         push_eol();
      end else if (r < 92) begin
         push_eol();
         push_word($urandom_range(1, 4));
      end
   endtask

   initial begin
      int idle;
      idle = 0;
      do @(posedge clock); while (reset !== 1'b0);
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int  r;
      int  n;
      bit  held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_trigger && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 8);
         end else if (r < 70) begin
            rsp_ready <= 1'b1;
            n = $urandom_range(40, 150);
         end else if (r < 95) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 3);
         end else begin
            rsp_ready <= 1'b0;
            n = $urandom_range(15, 50);
         end
         repeat (n) @(posedge clock);
      end
   end

   initial begin
      int r;
      int n;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data_byte    <= '0;
      req_packet_start <= 1'b0;
      req_packet_end   <= 1'b0;
      hold_trigger     <= 1'b0;
      bytes_sent       = 0;
      ends_sent        = 0;
      datagrams_sent   = 0;
      no_idle          = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // bytes ahead of any start, then a max byte that closes the datagram
      push_text("Q");
      datagram.push_back(8'hFF);
      send_datagram(1'b0, 1'b1, 1'b0);
      // unknown method drops into abort on the space
      push_text("GET ");
      send_datagram(1'b1, 1'b1, 1'b0);
      // single-byte datagram, zero byte
      datagram.push_back(8'h00);
      send_datagram(1'b1, 1'b1, 1'b0);
      // NOTIFY request carried over an unmarked continuation
      push_text("NOTIFY * ");
      send_datagram(1'b1, 1'b0, 1'b0);
      push_text("X");
      push_eol();
      push_eol();
      send_datagram(1'b0, 1'b1, 1'b0);
      // byte after an end with no new start
      datagram.push_back(8'h80);
      send_datagram(1'b0, 1'b1, 1'b0);

      n = 0;
      while (bytes_sent < ITEM_TARGET || ends_sent < OUTCOME_TARGET) begin
         n++;
         if (n == 6) begin
            hold_trigger <= 1'b1;
            repeat (12) begin
               push_noise($urandom_range(1, 3));
               send_datagram(1'b1, 1'b1, 1'b0);
            end
         end
         no_idle = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 75) build_request();
         else push_noise($urandom_range(1, 10));
         if ($urandom_range(0, 9) == 0)
            datagram[$urandom_range(0, datagram.size() - 1)] = 8'($urandom_range(0, 255));
         send_datagram($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0, 1'b1);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (outcomes_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d datagrams with %0d end marks.",
               bytes_sent, datagrams_sent, ends_sent);
      $display("Checked %0d outcomes: %0d accepted, %0d rejected, %0d mismatches.",
               outcome_count, accept_count, reject_count, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
